// ===== hw/rtl/chp8_pkg.sv =====
package chp8_pkg;

  // Fixed machine geometry
  localparam int MEM_DEPTH   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int MEM_AW      = 12;
  localparam int VRAM_AW     = 8;   // one byte holds eight pixels of a row
  localparam int REG_AW      = 4;

  localparam logic [11:0] PC_START  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam int          FONT_LEN  = 80;

  // Item operations
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Special instructions
  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  // Instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  // ALU sub-ops (8XYn)
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Key group low bytes
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  // Misc group low bytes
  localparam logic [7:0] MSC_GDLY = 8'h07;
  localparam logic [7:0] MSC_WKEY = 8'h0A;
  localparam logic [7:0] MSC_SDLY = 8'h15;
  localparam logic [7:0] MSC_SSND = 8'h18;
  localparam logic [7:0] MSC_ADDI = 8'h1E;
  localparam logic [7:0] MSC_FONT = 8'h29;
  localparam logic [7:0] MSC_BCD  = 8'h33;
  localparam logic [7:0] MSC_STR  = 8'h55;
  localparam logic [7:0] MSC_LDR  = 8'h65;

  localparam logic [7:0] FONT_GLYPHS [0:FONT_LEN-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Reset image of main memory: font glyphs at FONT_BASE, zero elsewhere
  function automatic logic [7:0] boot_byte(input logic [11:0] a);
    logic [11:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && off < 12'(FONT_LEN)) return FONT_GLYPHS[off[6:0]];
    else return 8'h00;
  endfunction

endpackage

// ===== hw/rtl/chp8_ram.sv =====
// Simple dual-port synchronous RAM, registered read
module chp8_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/chip8_instruction_step.sv =====
// One item per handshake; no new item is taken while one is in flight.
// 00E0, DXYN, FX33 and FX55/FX65 walk main memory or display RAM byte by
// byte.
// After reset a clearing pass loads the font and clears memory, display
// and V registers; no item is taken during it. PC resets to 0x200.
module chip8_instruction_step #(
  parameter int STACK_DEPTH = chp8_pkg::STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] keys,
  input  logic [7:0]  random_byte,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [11:0] program_counter,
  output logic        redraw,
  output logic        waiting_key,
  output logic [7:0]  delay_value,
  output logic [7:0]  sound_value
);

  localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_VRD, S_F1, S_F2, S_DEC, S_RVY, S_EXEC, S_W2, S_CLS,
    S_DR_RD, S_DR_A, S_DR_B, S_DR_C, S_DR_VF, S_BCD, S_ST, S_ST2, S_LD, S_LD2,
    S_DONE
  } state_t;

  state_t state;

  // Memory ports
  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic        vr_we;
  logic [7:0]  vr_waddr, vr_raddr, vr_wdata, vr_rdata;
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [7:0]  rf_wdata, rf_rdata;

  // Core state
  logic [11:0] cnt;
  logic [15:0] opc;
  logic [7:0]  vx, vy, line, alu_val, rd_r;
  logic [3:0]  k;
  logic        hit, redraw_r, wait_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic [11:0] pc, idx;
  logic [SPW-1:0] sp;
  logic [11:0] stack [0:STACK_DEPTH-1];
  logic [7:0]  delay_r, sound_r;

  chp8_ram #(.WIDTH(8), .AW(chp8_pkg::MEM_AW)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  chp8_ram #(.WIDTH(8), .AW(chp8_pkg::VRAM_AW)) u_vram (
    .clk, .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
    .raddr(vr_raddr), .rdata(vr_rdata)
  );

  chp8_ram #(.WIDTH(8), .AW(chp8_pkg::REG_AW)) u_regs (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  // Instruction fields
  logic [3:0]  grp, x, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  assign grp = opc[15:12];
  assign x   = opc[11:8];
  assign n   = opc[3:0];
  assign nn  = opc[7:0];
  assign nnn = opc[11:0];

  // ALU for 8XYn; vy comes straight off the register file in S_EXEC
  logic [7:0] alu_res, pa, pb, fa, fb;
  logic       alu_flag, alu_sets_flag, xf, yf;
  logic [8:0] add9;
  always_comb begin
    xf            = (x == 4'hF);
    yf            = (opc[7:4] == 4'hF);
    // operands as seen once VF has been cleared (8XY5, 8XY7)
    fa            = xf ? 8'h00 : vx;
    fb            = yf ? 8'h00 : rf_rdata;
    add9          = {1'b0, vx} + {1'b0, rf_rdata};
    alu_res       = vx;
    alu_flag      = 1'b0;
    alu_sets_flag = 1'b0;
    pa            = vx;
    pb            = rf_rdata;
    case (n)
      chp8_pkg::ALU_ADD: begin alu_flag = add9[8];        alu_sets_flag = 1'b1; end
      chp8_pkg::ALU_SUB: begin alu_flag = (fa >= fb);     alu_sets_flag = 1'b1; end
      chp8_pkg::ALU_SHR: begin alu_flag = vx[0];          alu_sets_flag = 1'b1; end
      chp8_pkg::ALU_SBN: begin alu_flag = (fb >= fa);     alu_sets_flag = 1'b1; end
      chp8_pkg::ALU_SHL: begin alu_flag = vx[7];          alu_sets_flag = 1'b1; end
      default: ;
    endcase
    // VF is written before VX, so a VF operand reads the new flag
    if (alu_sets_flag) begin
      if (xf) pa = {7'b0, alu_flag};
      if (yf) pb = {7'b0, alu_flag};
    end
    case (n)
      chp8_pkg::ALU_MOV: alu_res = rf_rdata;
      chp8_pkg::ALU_OR:  alu_res = vx | rf_rdata;
      chp8_pkg::ALU_AND: alu_res = vx & rf_rdata;
      chp8_pkg::ALU_XOR: alu_res = vx ^ rf_rdata;
      chp8_pkg::ALU_ADD: alu_res = pa + pb;
      chp8_pkg::ALU_SUB: alu_res = pa - pb;
      chp8_pkg::ALU_SHR: alu_res = {1'b0, pa[7:1]};
      chp8_pkg::ALU_SBN: alu_res = pb - pa;
      chp8_pkg::ALU_SHL: alu_res = {pa[6:0], 1'b0};
      default: ;
    endcase
  end

  // Lowest pressed key
  logic       key_any;
  logic [3:0] key_low;
  always_comb begin
    key_any = |keys_r;
    key_low = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_r[i]) key_low = 4'(i);
    end
  end

  logic key_dn;
  assign key_dn = keys_r[vx[3:0]];

  // BCD digits of vx
  logic [1:0] hund;
  logic [7:0] rem8;
  logic [3:0] tens;
  logic [6:0] ones7;
  always_comb begin
    if (vx >= 8'd200) begin
      hund = 2'd2; rem8 = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      hund = 2'd1; rem8 = vx - 8'd100;
    end else begin
      hund = 2'd0; rem8 = vx;
    end
    tens = 4'd0;
    for (int t = 1; t < 10; t++) begin
      if (rem8[6:0] >= 7'(t * 10)) tens = 4'(t);
    end
    ones7 = rem8[6:0] - 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
  end

  // Sprite geometry
  logic [5:0]  row_sum;
  logic [2:0]  b0, b1;
  logic [15:0] wide;
  logic [7:0]  m0, m1;
  assign row_sum = {1'b0, vy[4:0]} + {2'b00, k};
  assign b0      = vx[5:3];
  assign b1      = b0 + 3'd1;
  assign wide    = {line, 8'h00} >> vx[2:0];
  assign m0      = wide[15:8];
  assign m1      = wide[7:0];

  // FX1E sum
  logic [12:0] isum;
  assign isum = {1'b0, idx} + {5'b0, vx};

  logic [SPW-1:0] sp_dec, sp_inc;
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - 1'b1;
  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;

  assign in_ready = (state == S_IDLE);

  // Memory port steering
  always_comb begin
    mem_we = 1'b0; mem_waddr = idx; mem_wdata = 8'h00; mem_raddr = pc;
    vr_we = 1'b0;
    vr_wdata = 8'h00; vr_raddr = address[7:0];
    rf_we = 1'b0; rf_waddr = x; rf_wdata = alu_val; rf_raddr = x;
    vr_waddr = {row_sum[4:0], b0};
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1; mem_waddr = cnt; mem_wdata = chp8_pkg::boot_byte(cnt);
        vr_we = 1'b1; vr_waddr = cnt[7:0];
        rf_we = 1'b1; rf_waddr = cnt[3:0]; rf_wdata = 8'h00;
      end
      S_IDLE: begin
        mem_we = in_valid && (op == chp8_pkg::OP_WRITE);
        mem_waddr = address; mem_wdata = write_data;
      end
      S_F1:  mem_raddr = pc + 12'd1;
      S_DEC: rf_raddr = (grp == chp8_pkg::GRP_JPV0) ? 4'h0 : x;
      S_RVY: rf_raddr = opc[7:4];
      S_EXEC: begin
        unique case (grp)
          chp8_pkg::GRP_LDI: begin rf_we = 1'b1; rf_wdata = nn; end
          chp8_pkg::GRP_ADDI: begin rf_we = 1'b1; rf_wdata = vx + nn; end
          chp8_pkg::GRP_RND: begin rf_we = 1'b1; rf_wdata = rnd_r & nn; end
          chp8_pkg::GRP_ALU: begin
            rf_we = 1'b1;
            if (alu_sets_flag) begin
              rf_waddr = 4'hF; rf_wdata = {7'b0, alu_flag};
            end else begin
              rf_wdata = alu_res;
            end
            if (n > chp8_pkg::ALU_SBN && n != chp8_pkg::ALU_SHL) rf_we = 1'b0;
          end
          chp8_pkg::GRP_MISC: begin
            case (nn)
              chp8_pkg::MSC_GDLY: begin rf_we = 1'b1; rf_wdata = delay_r; end
              chp8_pkg::MSC_WKEY: begin rf_we = key_any; rf_wdata = {4'b0, key_low}; end
              chp8_pkg::MSC_ADDI: begin
                rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'b0, isum[12]};
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_W2: rf_we = 1'b1;
      S_CLS: begin vr_we = 1'b1; vr_waddr = cnt[7:0]; end
      S_DR_RD: mem_raddr = idx + {8'b0, k};
      S_DR_A: vr_raddr = {row_sum[4:0], b0};
      S_DR_B: begin
        vr_we = 1'b1; vr_waddr = {row_sum[4:0], b0}; vr_wdata = vr_rdata ^ m0;
        vr_raddr = {row_sum[4:0], b1};
      end
      S_DR_C: begin
        vr_we = 1'b1; vr_waddr = {row_sum[4:0], b1}; vr_wdata = vr_rdata ^ m1;
      end
      S_DR_VF: begin rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'b0, hit}; end
      S_BCD: begin
        mem_we = 1'b1; mem_waddr = idx + {8'b0, k};
        mem_wdata = (k == 4'd0) ? {6'b0, hund} :
                    (k == 4'd1) ? {4'b0, tens} : {1'b0, ones7};
      end
      S_ST: rf_raddr = k;
      S_ST2: begin
        mem_we = 1'b1; mem_waddr = idx + {8'b0, k}; mem_wdata = rf_rdata;
        rf_raddr = k + 4'd1;
      end
      S_LD: mem_raddr = idx + {8'b0, k};
      S_LD2: begin
        rf_we = 1'b1; rf_waddr = k; rf_wdata = mem_rdata;
        mem_raddr = idx + {8'b0, k} + 12'd1;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      pc        <= chp8_pkg::PC_START;
      idx       <= '0;
      sp        <= '0;
      delay_r   <= '0;
      sound_r   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 12'd1;
          if (cnt == 12'hFFF) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            keys_r   <= keys;
            rnd_r    <= random_byte;
            rd_r     <= 8'h00;
            redraw_r <= 1'b0;
            wait_r   <= 1'b0;
            case (op)
              chp8_pkg::OP_EXEC: state <= S_F1;
              chp8_pkg::OP_READ: state <= S_VRD;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_VRD: begin rd_r <= vr_rdata; state <= S_DONE; end
        S_F1:  begin opc[15:8] <= mem_rdata; state <= S_F2; end
        S_F2:  begin opc[7:0] <= mem_rdata; pc <= pc + 12'd2; state <= S_DEC; end
        S_DEC: state <= S_RVY;
        S_RVY: begin vx <= rf_rdata; state <= S_EXEC; end
        S_EXEC: begin
          vy    <= rf_rdata;
          state <= S_DONE;
          unique case (grp)
            chp8_pkg::GRP_SYS: begin
              if (opc == chp8_pkg::OPC_CLS) begin
                cnt <= '0; state <= S_CLS;
              end else if (opc == chp8_pkg::OPC_RET) begin
                sp <= sp_dec; pc <= stack[sp_dec];
              end
            end
            chp8_pkg::GRP_JP: pc <= nnn;
            chp8_pkg::GRP_CALL: begin
              stack[sp] <= pc; sp <= sp_inc; pc <= nnn;
            end
            chp8_pkg::GRP_SEI:  if (vx == nn) pc <= pc + 12'd2;
            chp8_pkg::GRP_SNEI: if (vx != nn) pc <= pc + 12'd2;
            chp8_pkg::GRP_SER:  if (vx == rf_rdata) pc <= pc + 12'd2;
            chp8_pkg::GRP_SNER: if (vx != rf_rdata) pc <= pc + 12'd2;
            chp8_pkg::GRP_LDI, chp8_pkg::GRP_ADDI, chp8_pkg::GRP_RND: ;
            chp8_pkg::GRP_ALU: begin
              alu_val <= alu_res;
              if (alu_sets_flag) state <= S_W2;
            end
            chp8_pkg::GRP_LDIX: idx <= nnn;
            chp8_pkg::GRP_JPV0: pc <= nnn + {4'b0, vx};
            chp8_pkg::GRP_DRW: begin
              k <= '0; hit <= 1'b0; state <= S_DR_RD;
            end
            chp8_pkg::GRP_KEY: begin
              if (nn == chp8_pkg::KEY_SKP && key_dn) pc <= pc + 12'd2;
              if (nn == chp8_pkg::KEY_SKNP && !key_dn) pc <= pc + 12'd2;
            end
            chp8_pkg::GRP_MISC: begin
              case (nn)
                chp8_pkg::MSC_SDLY: delay_r <= vx;
                chp8_pkg::MSC_SSND: sound_r <= vx;
                chp8_pkg::MSC_ADDI: begin
                  // with X = F the add sees the freshly written flag
                  if (x == 4'hF) idx <= idx + {11'b0, isum[12]};
                  else           idx <= isum[11:0];
                end
                chp8_pkg::MSC_WKEY: begin
                  if (!key_any) begin pc <= pc - 12'd2; wait_r <= 1'b1; end
                end
                chp8_pkg::MSC_FONT:
                  idx <= chp8_pkg::FONT_BASE + {6'b0, vx[3:0], 2'b00} + {8'b0, vx[3:0]};
                chp8_pkg::MSC_BCD: begin k <= '0; state <= S_BCD; end
                chp8_pkg::MSC_STR: begin k <= '0; state <= S_ST; end
                chp8_pkg::MSC_LDR: begin k <= '0; state <= S_LD; end
                default: ;
              endcase
            end
          endcase
        end
        S_W2: state <= S_DONE;
        S_CLS: begin
          cnt <= cnt + 12'd1;
          if (cnt[7:0] == 8'hFF) state <= S_DONE;
        end
        // Sprite rows: fetch line, then read-modify-write one or two bytes
        S_DR_RD: begin
          if (k == n || row_sum[5]) state <= S_DR_VF;
          else state <= S_DR_A;
        end
        S_DR_A: begin line <= mem_rdata; state <= S_DR_B; end
        S_DR_B: begin
          hit      <= hit | (|(vr_rdata & m0));
          redraw_r <= redraw_r | (|m0);
          if (vx[2:0] != 3'd0 && b0 != 3'd7) begin
            state <= S_DR_C;
          end else begin
            k <= k + 4'd1; state <= S_DR_RD;
          end
        end
        S_DR_C: begin
          hit      <= hit | (|(vr_rdata & m1));
          redraw_r <= redraw_r | (|m1);
          k        <= k + 4'd1;
          state    <= S_DR_RD;
        end
        S_DR_VF: state <= S_DONE;
        S_BCD: begin
          k <= k + 4'd1;
          if (k == 4'd2) state <= S_DONE;
        end
        S_ST: state <= S_ST2;
        S_ST2: begin
          k <= k + 4'd1;
          if (k == x) state <= S_DONE;
        end
        S_LD: state <= S_LD2;
        S_LD2: begin
          k <= k + 4'd1;
          if (k == x) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            read_data       <= rd_r;
            program_counter <= pc;
            redraw          <= redraw_r;
            waiting_key     <= wait_r;
            delay_value     <= delay_r;
            sound_value     <= sound_r;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an item is in flight");

  a_clr_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !in_ready)
    else $error("input taken during clearing pass");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    32'(sp) < STACK_DEPTH)
    else $error("stack pointer out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat raised outside completion");

endmodule

// ===== tb/sv/chip8_instruction_step_test.sv =====
module chip8_instruction_step_test;

  typedef struct packed {
    logic [7:0]  rd;
    logic [11:0] pc;
    logic        drw;
    logic        wk;
    logic [7:0]  dly;
    logic [7:0]  snd;
  } step_out_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [11:0] addr;
    logic [7:0]  wd;
    bit          typed;
    step_out_t   res;
  } dir_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  op = chp8_pkg::OP_READ;
  logic [15:0] keys = '0;
  logic [7:0]  random_byte = '0;
  logic [11:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  read_data;
  logic [11:0] program_counter;
  logic        redraw;
  logic        waiting_key;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;

  chip8_instruction_step dut (.*);

  always #2 clk = ~clk;

  // machine state mirrored by the predictor
  logic [7:0]  mem_m [0:chp8_pkg::MEM_DEPTH-1];
  logic [7:0]  vreg [0:15];
  logic [11:0] stk_m [0:chp8_pkg::STACK_DEPTH-1];
  logic [3:0]  sp_m;
  logic [11:0] pc_m;
  logic [11:0] ix_m;
  logic        fb_m [0:chp8_pkg::SCREEN_W*chp8_pkg::SCREEN_H-1];
  logic [7:0]  dly_m, snd_m;

  step_out_t want_q [$];
  int errs = 0;
  int beats_out = 0;

  function automatic void machine_reset();
    for (int i = 0; i < chp8_pkg::MEM_DEPTH; i++) mem_m[i] = 8'h00;
    for (int i = 0; i < chp8_pkg::FONT_LEN; i++)
      mem_m[chp8_pkg::FONT_BASE + i] = chp8_pkg::FONT_GLYPHS[i];
    for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
    for (int i = 0; i < chp8_pkg::STACK_DEPTH; i++) stk_m[i] = 12'h000;
    for (int i = 0; i < chp8_pkg::SCREEN_W*chp8_pkg::SCREEN_H; i++) fb_m[i] = 1'b0;
    sp_m = '0; pc_m = chp8_pkg::PC_START; ix_m = '0; dly_m = '0; snd_m = '0;
  endfunction

  function automatic step_out_t chip8_predict(input logic [1:0] o, input logic [15:0] kb,
                                              input logic [7:0] rb, input logic [11:0] a,
                                              input logic [7:0] wd);
    step_out_t r;
    logic [15:0] opc;
    logic [3:0] x, y;
    logic [7:0] nn, spr, val;
    logic [11:0] nnn;
    logic [12:0] s13;
    logic [8:0] s9;
    int px, py, n, k, idx;
    logic hit;
    r = '0;
    if (o == chp8_pkg::OP_EXEC) begin
      opc = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
      x = opc[11:8]; y = opc[7:4]; nn = opc[7:0]; nnn = opc[11:0];
      pc_m = pc_m + 12'd2;
      case (opc[15:12])
        chp8_pkg::GRP_SYS: begin
          if (opc == chp8_pkg::OPC_CLS) begin
            for (int i = 0; i < chp8_pkg::SCREEN_W*chp8_pkg::SCREEN_H; i++) fb_m[i] = 1'b0;
          end else if (opc == chp8_pkg::OPC_RET) begin
            sp_m = sp_m - 4'd1;
            pc_m = stk_m[sp_m];
          end
        end
        chp8_pkg::GRP_JP: pc_m = nnn;
        chp8_pkg::GRP_CALL: begin
          stk_m[sp_m] = pc_m;
          sp_m = sp_m + 4'd1;
          pc_m = nnn;
        end
        chp8_pkg::GRP_SEI:  if (vreg[x] == nn) pc_m = pc_m + 12'd2;
        chp8_pkg::GRP_SNEI: if (vreg[x] != nn) pc_m = pc_m + 12'd2;
        chp8_pkg::GRP_SER:  if (vreg[x] == vreg[y]) pc_m = pc_m + 12'd2;
        chp8_pkg::GRP_LDI:  vreg[x] = nn;
        chp8_pkg::GRP_ADDI: vreg[x] = vreg[x] + nn;
        chp8_pkg::GRP_ALU: begin
          // flag is written before the destination, so X=F sees the new flag
          case (opc[3:0])
            chp8_pkg::ALU_MOV: vreg[x] = vreg[y];
            chp8_pkg::ALU_OR:  vreg[x] = vreg[x] | vreg[y];
            chp8_pkg::ALU_AND: vreg[x] = vreg[x] & vreg[y];
            chp8_pkg::ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
            chp8_pkg::ALU_ADD: begin
              s9 = {1'b0, vreg[x]} + {1'b0, vreg[y]};
              vreg[15] = {7'd0, s9[8]};
              vreg[x] = vreg[x] + vreg[y];
            end
            chp8_pkg::ALU_SUB: begin
              // VF is cleared first, then compared
              vreg[15] = 8'd0;
              if (vreg[x] >= vreg[y]) vreg[15] = 8'd1;
              vreg[x] = vreg[x] - vreg[y];
            end
            chp8_pkg::ALU_SHR: begin
              vreg[15] = {7'd0, vreg[x][0]};
              vreg[x] = vreg[x] >> 1;
            end
            chp8_pkg::ALU_SBN: begin
              vreg[15] = 8'd0;
              if (vreg[y] >= vreg[x]) vreg[15] = 8'd1;
              vreg[x] = vreg[y] - vreg[x];
            end
            chp8_pkg::ALU_SHL: begin
              vreg[15] = {7'd0, vreg[x][7]};
              vreg[x] = vreg[x] << 1;
            end
            default: ;
          endcase
        end
        chp8_pkg::GRP_SNER: if (vreg[x] != vreg[y]) pc_m = pc_m + 12'd2;
        chp8_pkg::GRP_LDIX: ix_m = nnn;
        chp8_pkg::GRP_JPV0: pc_m = nnn + {4'd0, vreg[0]};
        chp8_pkg::GRP_RND:  vreg[x] = rb & nn;
        chp8_pkg::GRP_DRW: begin
          // clipped sprite XOR, start position wraps
          px = vreg[x] % chp8_pkg::SCREEN_W;
          py = vreg[y] % chp8_pkg::SCREEN_H;
          n = opc[3:0];
          hit = 1'b0;
          for (int rr = 0; rr < n && py + rr < chp8_pkg::SCREEN_H; rr++) begin
            spr = mem_m[ix_m + 12'(rr)];
            for (int c = 0; c < 8 && px + c < chp8_pkg::SCREEN_W; c++) begin
              if (spr[7-c]) begin
                idx = (px + c) + chp8_pkg::SCREEN_W * (py + rr);
                r.drw = 1'b1;
                if (fb_m[idx]) hit = 1'b1;
                fb_m[idx] = ~fb_m[idx];
              end
            end
          end
          vreg[15] = {7'd0, hit};
        end
        chp8_pkg::GRP_KEY: begin
          if (nn == chp8_pkg::KEY_SKP) begin
            if (kb[vreg[x][3:0]]) pc_m = pc_m + 12'd2;
          end else if (nn == chp8_pkg::KEY_SKNP) begin
            if (!kb[vreg[x][3:0]]) pc_m = pc_m + 12'd2;
          end
        end
        default: begin
          case (nn)
            chp8_pkg::MSC_GDLY: vreg[x] = dly_m;
            chp8_pkg::MSC_SDLY: dly_m = vreg[x];
            chp8_pkg::MSC_SSND: snd_m = vreg[x];
            chp8_pkg::MSC_ADDI: begin
              s13 = {1'b0, ix_m} + {5'd0, vreg[x]};
              vreg[15] = {7'd0, s13[12]};
              s13 = {1'b0, ix_m} + {5'd0, vreg[x]};
              ix_m = s13[11:0];
            end
            chp8_pkg::MSC_WKEY: begin
              k = 16;
              for (int i = 15; i >= 0; i--) if (kb[i]) k = i;
              if (k < 16) vreg[x] = 8'(k);
              else begin
                pc_m = pc_m - 12'd2;
                r.wk = 1'b1;
              end
            end
            chp8_pkg::MSC_FONT: ix_m = 12'(vreg[x][3:0]) * 12'd5 + chp8_pkg::FONT_BASE;
            chp8_pkg::MSC_BCD: begin
              val = vreg[x];
              mem_m[ix_m] = 8'(val / 100);
              mem_m[ix_m + 12'd1] = 8'((val / 10) % 10);
              mem_m[ix_m + 12'd2] = 8'(val % 10);
            end
            chp8_pkg::MSC_STR:
              for (int i = 0; i <= x; i++) mem_m[ix_m + 12'(i)] = vreg[i];
            chp8_pkg::MSC_LDR:
              for (int i = 0; i <= x; i++) vreg[i] = mem_m[ix_m + 12'(i)];
            default: ;
          endcase
        end
      endcase
    end else if (o == chp8_pkg::OP_WRITE) begin
      mem_m[a] = wd;
    end else if (o == chp8_pkg::OP_READ) begin
      for (int b = 0; b < 8; b++) r.rd[7-b] = fb_m[a[7:0] * 8 + b];
    end
    r.pc = pc_m; r.dly = dly_m; r.snd = snd_m;
    return r;
  endfunction

  // offer one beat and wait for it to be taken; predict on acceptance
  task automatic send_beat(input logic [1:0] o, input logic [15:0] kb, input logic [7:0] rb,
                           input logic [11:0] a, input logic [7:0] wd,
                           input bit typed, input step_out_t tres);
    step_out_t p;
    int g;
    op <= o; keys <= kb; random_byte <= rb; address <= a; write_data <= wd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = chip8_predict(o, kb, rb, a, wd);
    want_q.push_back(typed ? tres : p);
    g = $urandom_range(0, 99);
    if (g < 55) g = 0;
    else if (g < 95) g = $urandom_range(1, 4);
    else g = $urandom_range(20, 120);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    step_out_t w;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat pc=%h", $time, program_counter);
        errs++;
      end else begin
        w = want_q.pop_front();
        if (read_data !== w.rd) begin
          $display("%0t: read_data exp %h got %h", $time, w.rd, read_data); errs++;
        end
        if (program_counter !== w.pc) begin
          $display("%0t: program_counter exp %h got %h", $time, w.pc, program_counter);
          errs++;
        end
        if (redraw !== w.drw) begin
          $display("%0t: redraw exp %b got %b", $time, w.drw, redraw); errs++;
        end
        if (waiting_key !== w.wk) begin
          $display("%0t: waiting_key exp %b got %b", $time, w.wk, waiting_key); errs++;
        end
        if (delay_value !== w.dly) begin
          $display("%0t: delay_value exp %h got %h", $time, w.dly, delay_value); errs++;
        end
        if (sound_value !== w.snd) begin
          $display("%0t: sound_value exp %h got %h", $time, w.snd, sound_value); errs++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    bit held;
    int r;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && beats_out >= 300) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) out_ready <= 1'b1;
        else if (r < 90) out_ready <= 1'b0;
        else if (r < 95) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 100)) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [15:0] rand_opcode();
    logic [3:0] g;
    logic [15:0] w;
    int s;
    g = 4'($urandom_range(0, 15));
    w = {g, 12'($urandom_range(0, 4095))};
    s = $urandom_range(0, 99);
    case (g)
      chp8_pkg::GRP_SYS: begin
        if (s < 5) w = chp8_pkg::OPC_CLS;
        else if (s < 60) w = chp8_pkg::OPC_RET;
      end
      chp8_pkg::GRP_DRW: if (s < 80) w[3:0] = 4'($urandom_range(0, 4));
      chp8_pkg::GRP_KEY: begin
        if (s < 45) w[7:0] = chp8_pkg::KEY_SKP;
        else if (s < 90) w[7:0] = chp8_pkg::KEY_SKNP;
      end
      chp8_pkg::GRP_MISC: begin
        case (s % 10)
          0: w[7:0] = chp8_pkg::MSC_GDLY;
          1: w[7:0] = chp8_pkg::MSC_WKEY;
          2: w[7:0] = chp8_pkg::MSC_SDLY;
          3: w[7:0] = chp8_pkg::MSC_SSND;
          4: w[7:0] = chp8_pkg::MSC_ADDI;
          5: w[7:0] = chp8_pkg::MSC_FONT;
          6: w[7:0] = chp8_pkg::MSC_BCD;
          7: w[7:0] = chp8_pkg::MSC_STR;
          8: w[7:0] = chp8_pkg::MSC_LDR;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_keys();
    if ($urandom_range(0, 3) == 0) return 16'h0000;
    return 16'($urandom);
  endfunction

  // directed rows: short program built through memory writes
  dir_row_t dir_tab [24];

  function automatic dir_row_t mk(input logic [1:0] o, input logic [15:0] kb,
                                  input logic [7:0] rb, input logic [11:0] a,
                                  input logic [7:0] wd, input bit typed,
                                  input logic [11:0] epc, input bit ewk,
                                  input logic [7:0] edly);
    dir_row_t d;
    d.op = o; d.keys = kb; d.rnd = rb; d.addr = a; d.wd = wd; d.typed = typed;
    d.res = '{rd: 8'h00, pc: epc, drw: 1'b0, wk: ewk, dly: edly, snd: 8'h00};
    return d;
  endfunction

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int items, s, lim;
    logic [15:0] w;
    machine_reset();
    dir_tab[0]  = mk(chp8_pkg::OP_READ,  16'h0000, 8'h00, 12'h000, 8'h00, 1, 12'h200, 0, 8'h00);
    dir_tab[1]  = mk(chp8_pkg::OP_READ,  16'hFFFF, 8'hFF, 12'hFFF, 8'hFF, 1, 12'h200, 0, 8'h00);
    dir_tab[2]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'hFFF, 8'hFF, 1, 12'h200, 0, 8'h00);
    dir_tab[3]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h200, 8'h60, 1, 12'h200, 0, 8'h00);
    dir_tab[4]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h201, 8'hFF, 1, 12'h200, 0, 8'h00);
    dir_tab[5]  = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 1, 12'h202, 0, 8'h00);
    dir_tab[6]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h202, 8'h80, 1, 12'h202, 0, 8'h00);
    dir_tab[7]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h203, 8'h0E, 1, 12'h202, 0, 8'h00);
    dir_tab[8]  = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 1, 12'h204, 0, 8'h00);
    dir_tab[9]  = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h204, 8'hF0, 1, 12'h204, 0, 8'h00);
    dir_tab[10] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h205, 8'h15, 1, 12'h204, 0, 8'h00);
    dir_tab[11] = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 1, 12'h206, 0, 8'hFE);
    dir_tab[12] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h206, 8'hF0, 1, 12'h206, 0, 8'hFE);
    dir_tab[13] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h207, 8'h0A, 1, 12'h206, 0, 8'hFE);
    // wait for key: none pressed, then only key F
    dir_tab[14] = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 1, 12'h206, 1, 8'hFE);
    dir_tab[15] = mk(chp8_pkg::OP_EXEC,  16'h8000, 8'h00, 12'h000, 8'h00, 1, 12'h208, 0, 8'hFE);
    dir_tab[16] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h208, 8'hA0, 0, 12'h000, 0, 8'h00);
    dir_tab[17] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h209, 8'h50, 0, 12'h000, 0, 8'h00);
    dir_tab[18] = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 0, 12'h000, 0, 8'h00);
    dir_tab[19] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h20A, 8'hD0, 0, 12'h000, 0, 8'h00);
    dir_tab[20] = mk(chp8_pkg::OP_WRITE, 16'h0000, 8'h00, 12'h20B, 8'h05, 0, 12'h000, 0, 8'h00);
    dir_tab[21] = mk(chp8_pkg::OP_EXEC,  16'h0000, 8'h00, 12'h000, 8'h00, 0, 12'h000, 0, 8'h00);
    dir_tab[22] = mk(chp8_pkg::OP_READ,  16'h0000, 8'h00, 12'd121, 8'h00, 0, 12'h000, 0, 8'h00);
    dir_tab[23] = mk(chp8_pkg::OP_EXEC,  16'hFFFF, 8'hFF, 12'hFFF, 8'hFF, 0, 12'h000, 0, 8'h00);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_beat(dir_tab[i].op, dir_tab[i].keys, dir_tab[i].rnd, dir_tab[i].addr,
                dir_tab[i].wd, dir_tab[i].typed, dir_tab[i].res);

    // random part: mostly planted instructions at the predicted pc, some noise
    items = 0;
    while (items < 1800) begin
      if (items >= 900 && items < 903) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (want_q.size() != 0) @(posedge clk);
        items = 903;
      end
      s = $urandom_range(0, 99);
      if (s < 80) begin
        w = rand_opcode();
        send_beat(chp8_pkg::OP_WRITE, rand_keys(), 8'($urandom), pc_m, w[15:8], 0, '0);
        send_beat(chp8_pkg::OP_WRITE, rand_keys(), 8'($urandom), pc_m + 12'd1, w[7:0],
                  0, '0);
        send_beat(chp8_pkg::OP_EXEC, rand_keys(), 8'($urandom), 12'($urandom),
                  8'($urandom), 0, '0);
        items += 3;
      end else if (s < 88) begin
        send_beat(chp8_pkg::OP_EXEC, rand_keys(), 8'($urandom), 12'($urandom),
                  8'($urandom), 0, '0);
        items++;
      end else if (s < 94) begin
        send_beat(chp8_pkg::OP_WRITE, rand_keys(), 8'($urandom), 12'($urandom),
                  8'($urandom), 0, '0);
        items++;
      end else begin
        send_beat(chp8_pkg::OP_READ, rand_keys(), 8'($urandom), 12'($urandom),
                  8'($urandom), 0, '0);
        items++;
      end
    end
    in_valid <= 1'b0;

    // drain, then a short tail for stray beats
    lim = 0;
    while (want_q.size() != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    repeat (400) @(posedge clk);
    if (errs == 0 && want_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
